// ----- sv/voau_pkg.sv -----
package voau_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int FB = PROB_FRAC_BITS;
    localparam int PW = FB + 1;          // probability width
    localparam int NW = FB + 2;          // numerator / denominator width
    localparam int XW = NW + FB;         // dividend width
    localparam int CW = 3;               // config index width

    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = PW;
    localparam int BLEND_STAGES = 2;

    localparam int LANE_HIT  = 0;
    localparam int LANE_MISS = 1;

    localparam logic [PW-1:0] PROB_ONE = {1'b1, {FB{1'b0}}};
    localparam logic [2*PW-1:0] PMUL_HALF = (2*PW)'(1) << (FB - 1);
    localparam logic [2*PW:0] BLEND_HALF = (2*PW+1)'(1) << (FB - 1);

    localparam logic [PW-1:0] RST_HIT_OCC  = PW'(45875);
    localparam logic [PW-1:0] RST_HIT_FREE = PW'(26214);
    localparam logic [PW-1:0] RST_HIT_HID  = PW'(32768);
    localparam logic [PW-1:0] RST_CLAMP_LO = PW'(7864);
    localparam logic [PW-1:0] RST_CLAMP_HI = PW'(63570);

    typedef logic [CW-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HIT_OCC  = 3'd0;
    localparam t_cfg_idx CFG_HIT_FREE = 3'd1;
    localparam t_cfg_idx CFG_HIT_HID  = 3'd2;
    localparam t_cfg_idx CFG_CLAMP_LO = 3'd3;
    localparam t_cfg_idx CFG_CLAMP_HI = 3'd4;

    typedef enum logic [1:0] {
        MC_MISS,
        MC_HIT,
        MC_BLEND
    } t_mcase;

    typedef struct packed {
        logic [PW-1:0] prior_occupancy;
        logic [PW-1:0] visibility;
        logic [PW-1:0] measured_occupancy;
    } t_in;

    typedef struct packed {
        logic [PW-1:0] new_occupancy;
        logic          zero_denominator;
    } t_out;

    // saturated register values
    typedef struct packed {
        logic [PW-1:0] ho;
        logic [PW-1:0] hf;
        logic [PW-1:0] hh;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
    } t_cfg;

    typedef struct packed {
        logic [PW-1:0] p;
        logic [PW-1:0] m;
        t_mcase        mcase;
        logic          zero_hit;
        logic          zero_miss;
    } t_side;

    typedef struct packed {
        logic [XW-1:0] dvd;
        logic [NW-1:0] den;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [1:0] lane;
        t_side           side;
    } t_div_in;

    typedef struct packed {
        logic [1:0][PW-1:0] q;
        t_side              side;
    } t_div_out;

    function automatic logic [PW-1:0] sat_one(input logic [PW-1:0] x);
        return (x > PROB_ONE) ? PROB_ONE : x;
    endfunction

    // rounded product, half up
    function automatic logic [PW-1:0] pmul(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [2*PW-1:0] prod;
        prod = (2*PW)'(a) * (2*PW)'(b);
        prod = prod + PMUL_HALF;
        return prod[FB+PW-1:FB];
    endfunction

endpackage

// ----- sv/voau_cfg.sv -----
module voau_cfg import voau_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  t_cfg_idx      i_cfg_index,
    input  logic [PW-1:0] i_cfg_data,
    output t_cfg          o_cfg
);

    logic [PW-1:0] r_ho, r_hf, r_hh, r_lo, r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ho <= RST_HIT_OCC;
            r_hf <= RST_HIT_FREE;
            r_hh <= RST_HIT_HID;
            r_lo <= RST_CLAMP_LO;
            r_hi <= RST_CLAMP_HI;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIT_OCC:  r_ho <= i_cfg_data;
                CFG_HIT_FREE: r_hf <= i_cfg_data;
                CFG_HIT_HID:  r_hh <= i_cfg_data;
                CFG_CLAMP_LO: r_lo <= i_cfg_data;
                CFG_CLAMP_HI: r_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.ho = sat_one(r_ho);
    assign o_cfg.hf = sat_one(r_hf);
    assign o_cfg.hh = sat_one(r_hh);
    assign o_cfg.lo = sat_one(r_lo);
    assign o_cfg.hi = sat_one(r_hi);

endmodule

// ----- sv/voau_front.sv -----
module voau_front import voau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in     i_data,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    input  logic    i_ready,
    output t_div_in o_data
);

    typedef struct packed {
        logic [PW-1:0] mo;
        logic [PW-1:0] mf;
        logic [PW-1:0] mh;
    } t_coef;

    typedef struct packed {
        t_coef [1:0]   coef;
        logic [PW-1:0] v;
        logic [PW-1:0] omv;
        logic [PW-1:0] omp;
        t_side         side;
    } t_s1;

    typedef struct packed {
        logic [PW-1:0] a;
        logic [PW-1:0] hid;
        logic [PW-1:0] b;
    } t_prod1;

    typedef struct packed {
        t_prod1 [1:0]  lane;
        logic [PW-1:0] omp;
        t_side         side;
    } t_s2;

    typedef struct packed {
        logic [PW-1:0] occ;
        logic [PW-1:0] hocc;
        logic [PW-1:0] free;
        logic [PW-1:0] hid;
    } t_prod2;

    typedef struct packed {
        t_prod2 [1:0] lane;
        t_side        side;
    } t_s3;

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES:0]   en;

    t_s1     r_s1, n_s1;
    t_s2     r_s2, n_s2;
    t_s3     r_s3, n_s3;
    t_div_in r_s4, n_s4;

    always_comb begin
        en[FRONT_STAGES] = i_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: saturate, select measurement models
    always_comb begin
        logic [PW-1:0] p, v, m;
        p = sat_one(i_data.prior_occupancy);
        v = sat_one(i_data.visibility);
        m = sat_one(i_data.measured_occupancy);
        n_s1.side.p         = p;
        n_s1.side.m         = m;
        n_s1.side.zero_hit  = 1'b0;
        n_s1.side.zero_miss = 1'b0;
        if (m == '0)
            n_s1.side.mcase = MC_MISS;
        else if (m == PROB_ONE)
            n_s1.side.mcase = MC_HIT;
        else
            n_s1.side.mcase = MC_BLEND;
        n_s1.v   = v;
        n_s1.omv = PROB_ONE - v;
        n_s1.omp = PROB_ONE - p;
        n_s1.coef[LANE_HIT].mo  = i_cfg.ho;
        n_s1.coef[LANE_HIT].mf  = i_cfg.hf;
        n_s1.coef[LANE_HIT].mh  = i_cfg.hh;
        n_s1.coef[LANE_MISS].mo = PROB_ONE - i_cfg.ho;
        n_s1.coef[LANE_MISS].mf = PROB_ONE - i_cfg.hf;
        // blend keeps the hit probability for the hidden term
        n_s1.coef[LANE_MISS].mh = (m == '0) ? (PROB_ONE - i_cfg.hh) : i_cfg.hh;
    end

    // stage 2: first products
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_s2.lane[l].a   = pmul(r_s1.coef[l].mo, r_s1.v);
            n_s2.lane[l].hid = pmul(r_s1.coef[l].mh, r_s1.omv);
            n_s2.lane[l].b   = pmul(r_s1.coef[l].mf, r_s1.v);
        end
        n_s2.omp  = r_s1.omp;
        n_s2.side = r_s1.side;
    end

    // stage 3: second products
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_s3.lane[l].occ  = pmul(r_s2.lane[l].a, r_s2.side.p);
            n_s3.lane[l].hocc = pmul(r_s2.lane[l].hid, r_s2.side.p);
            n_s3.lane[l].free = pmul(r_s2.lane[l].b, r_s2.omp);
            n_s3.lane[l].hid  = r_s2.lane[l].hid;
        end
        n_s3.side = r_s2.side;
    end

    // stage 4: numerator, denominator, rounded dividend
    always_comb begin
        logic [NW-1:0] num [2];
        logic [NW-1:0] den [2];
        for (int l = 0; l < 2; l++) begin
            num[l] = NW'(r_s3.lane[l].occ) + NW'(r_s3.lane[l].hocc);
            den[l] = NW'(r_s3.lane[l].occ) + NW'(r_s3.lane[l].free)
                   + NW'(r_s3.lane[l].hid);
            n_s4.lane[l].dvd = {num[l], {FB{1'b0}}} + XW'(den[l] >> 1);
            n_s4.lane[l].den = den[l];
        end
        n_s4.side           = r_s3.side;
        n_s4.side.zero_hit  = (den[LANE_HIT] == '0);
        n_s4.side.zero_miss = (den[LANE_MISS] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_s1 <= n_s1;
        if (en[1]) r_s2 <= n_s2;
        if (en[2]) r_s3 <= n_s3;
        if (en[3]) r_s4 <= n_s4;
    end

    assign o_ready = en[0];
    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_data  = r_s4;

endmodule

// ----- sv/voau_div.sv -----
module voau_div import voau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_div_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_div_out o_data
);

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES:0]   en;

    logic [XW-1:0] r_rem [DIV_STAGES][2];
    logic [NW-1:0] r_den [DIV_STAGES][2];
    logic [PW-1:0] r_q   [DIV_STAGES][2];
    t_side         r_side [DIV_STAGES];

    logic [XW-1:0] n_rem [DIV_STAGES][2];
    logic [NW-1:0] n_den [DIV_STAGES][2];
    logic [PW-1:0] n_q   [DIV_STAGES][2];
    t_side         n_side [DIV_STAGES];

    always_comb begin
        en[DIV_STAGES] = i_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    always_comb begin
        logic [XW-1:0] rem, dsh;
        logic [NW-1:0] den;
        logic [PW-1:0] q;
        for (int s = 0; s < DIV_STAGES; s++) begin
            n_side[s] = (s == 0) ? i_data.side : r_side[s-1];
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    rem = i_data.lane[l].dvd;
                    den = i_data.lane[l].den;
                    q   = '0;
                end else begin
                    rem = r_rem[s-1][l];
                    den = r_den[s-1][l];
                    q   = r_q[s-1][l];
                end
                dsh = XW'(den) << (PW - 1 - s);
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    q   = q | (PW'(1) << (PW - 1 - s));
                end
                n_rem[s][l] = rem;
                n_den[s][l] = den;
                n_q[s][l]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (en[s]) begin
                r_side[s] <= n_side[s];
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_den[s][l] <= n_den[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_data.q[LANE_HIT]  = r_q[DIV_STAGES-1][LANE_HIT];
    assign o_data.q[LANE_MISS] = r_q[DIV_STAGES-1][LANE_MISS];
    assign o_data.side         = r_side[DIV_STAGES-1];

endmodule

// ----- sv/voau_blend.sv -----
module voau_blend import voau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_div_out i_data,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out     o_data
);

    logic [BLEND_STAGES-1:0] r_v;
    logic [BLEND_STAGES:0]   en;

    logic [2*PW-1:0] r_ph, r_pm;
    logic [PW-1:0]   r_qh, r_qm;
    t_side           r_side;
    t_out            r_out, n_out;

    always_comb begin
        en[BLEND_STAGES] = i_ready;
        for (int k = BLEND_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < BLEND_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: weighted products
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ph   <= (2*PW)'(i_data.side.m) * (2*PW)'(i_data.q[LANE_HIT]);
            r_pm   <= (2*PW)'(PROB_ONE - i_data.side.m) * (2*PW)'(i_data.q[LANE_MISS]);
            r_qh   <= i_data.q[LANE_HIT];
            r_qm   <= i_data.q[LANE_MISS];
            r_side <= i_data.side;
        end
    end

    // stage 2: blend, clamp, zero-denominator fallback
    always_comb begin
        logic [2*PW:0] sum;
        logic [PW-1:0] mix;
        sum = (2*PW+1)'(r_ph) + (2*PW+1)'(r_pm) + BLEND_HALF;
        mix = sum[FB+PW-1:FB];
        n_out.new_occupancy    = r_side.p;
        n_out.zero_denominator = 1'b1;
        unique case (r_side.mcase)
            MC_MISS: begin
                if (!r_side.zero_miss) begin
                    n_out.zero_denominator = 1'b0;
                    n_out.new_occupancy = (r_qm > i_cfg.lo) ? r_qm : i_cfg.lo;
                end
            end
            MC_HIT: begin
                if (!r_side.zero_hit) begin
                    n_out.zero_denominator = 1'b0;
                    n_out.new_occupancy = (r_qh < i_cfg.hi) ? r_qh : i_cfg.hi;
                end
            end
            default: begin
                if (!r_side.zero_hit && !r_side.zero_miss) begin
                    n_out.zero_denominator = 1'b0;
                    if (mix < i_cfg.lo)
                        n_out.new_occupancy = i_cfg.lo;
                    else if (mix > i_cfg.hi)
                        n_out.new_occupancy = i_cfg.hi;
                    else
                        n_out.new_occupancy = mix;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) r_out <= n_out;
    end

    assign o_ready = en[0];
    assign o_valid = r_v[BLEND_STAGES-1];
    assign o_data  = r_out;

endmodule

// ----- sv/visibility_aware_occupancy_update_top.sv -----
// Visibility-aware Bayesian occupancy update, one voxel per item. Each item
// gives a prior, a visibility and a measurement (Q1.16); the result is the
// clamped posterior and a flag that is set when a denominator was zero, in
// which case the saturated prior is returned. Fully pipelined: one item per
// cycle sustained while the output is not stalled, through 4 front stages
// (saturation and model select, two product levels and the sums), 17
// restoring-divider stages at one quotient bit each and 2 blend/clamp stages.
// Each stage holds under backpressure and bubbles collapse, so the input
// keeps accepting while a result waits until all 23 stages are occupied.
// Configuration writes are always accepted and must only be made while no
// item is in flight.
module visibility_aware_occupancy_update_top import voau_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in           i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out          o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  t_cfg_idx      i_cfg_index,
    input  logic [PW-1:0] i_cfg_data
);

    t_cfg     cfg;
    logic     front_valid, front_ready;
    t_div_in  front_data;
    logic     div_valid, div_ready;
    t_div_out div_data;

    assign o_cfg_ready = 1'b1;

    voau_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    voau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_data)
    );

    voau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_data)
    );

    voau_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_data  (div_data),
        .i_cfg   (cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
